// ===== hdl/sol_pkg.sv =====
// ----------------------------------------------------------------------------
// sol_pkg
// Shared types and constants for the search open list table: operation and
// status codes, the stored node layout and the sequencer states.
// ----------------------------------------------------------------------------
package sol_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_BEST   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMV_CAP,
        ST_SHIFT,
        ST_SCAN
    } t_state;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned COST_W  = 24;
    localparam int unsigned SUM_W   = COST_W + 1;

    // 10000.0 in unsigned Q17.8
    localparam logic [SUM_W-1:0] COST_LIMIT = SUM_W'(10000 * 256);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COST_W-1:0]  g;
        logic [COST_W-1:0]  h;
    } t_node;

    localparam int unsigned NODE_W = $bits(t_node);

    typedef struct packed {
        logic             match;
        logic             less;
        logic [SUM_W-1:0] sum;
    } t_eval;

endpackage

// ===== hdl/search_open_list_table_top.sv =====
// ----------------------------------------------------------------------------
// search_open_list_table_top
// Open list of a path search held as a ring table in one RAM, with add,
// remove at slot, find by position and find least cost under a sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake            | beat
//  ----------+----------------------+------------------------------------------
//  command   | start, busy          | operation, slot, position, g, h
//  result    | o_done (strobe)      | status, index, removed node, empty flag
//
//  add writes the tail slot; remove captures the slot, then moves each entry
//  from head to slot up one place, one RAM read and one RAM write per entry;
//  find and best sweep the RAM one slot a cycle, ending early on a find match
//  the result strobe comes in the cycle after the last step; busy is low then
//  synchronous reset empties the table at once, no clearing pass
//  results are never stalled
// ----------------------------------------------------------------------------
module search_open_list_table_top #(
    parameter int unsigned SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_operation,
    input  logic [5:0]           i_slot_index,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [23:0]          i_path_cost,
    input  logic [23:0]          i_estimate_cost,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [5:0]           o_found_index,
    output logic signed [15:0]   o_out_pos_x,
    output logic signed [15:0]   o_out_pos_y,
    output logic [23:0]          o_out_path_cost,
    output logic [23:0]          o_out_estimate_cost,
    output logic                 o_is_empty
);

    import sol_pkg::*;

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [IW-1:0]     r_it, n_it;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    t_op               r_op, n_op;
    logic [COORD_W-1:0] r_key_x, n_key_x;
    logic [COORD_W-1:0] r_key_y, n_key_y;
    logic [SUM_W-1:0]  r_best, n_best;
    logic [IW-1:0]     r_bidx, n_bidx;
    logic              r_bfound, n_bfound;

    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [5:0]        r_found, n_found;
    t_node             r_onode, n_onode;
    logic              r_empty, n_empty;

    logic              we;
    logic [IW-1:0]     waddr;
    t_node             wdata;
    logic [IW-1:0]     raddr;
    t_node             rdata;
    t_eval             ev;

    logic              fin;
    t_status           fin_status;
    logic [IW-1:0]     fin_idx;
    logic [IW+5:0]     slot_ext;
    logic [IW-1:0]     slot_iw;
    logic              slot_ok;
    logic [IW-1:0]     eidx;
    logic [IW-1:0]     prev_it;
    logic [IW+5:0]     fin_ext;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
        next_slot = (s == LAST) ? '0 : s + IW'(1);
    endfunction

    function automatic logic [IW-1:0] prev_slot(input logic [IW-1:0] s);
        prev_slot = (s == '0) ? LAST : s - IW'(1);
    endfunction

    function automatic logic in_ring(input logic [IW-1:0] s, input logic [IW-1:0] hd,
                                     input logic [IW-1:0] tl);
        if (hd <= tl) begin
            in_ring = (s >= hd) && (s < tl);
        end else begin
            in_ring = (s >= hd) || (s < tl);
        end
    endfunction

    sol_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sol_eval u_eval (
        .i_node  (rdata),
        .i_key_x (r_key_x),
        .i_key_y (r_key_y),
        .i_best  (r_best),
        .o_res   (ev)
    );

    assign slot_ext = {{IW{1'b0}}, i_slot_index};
    assign slot_iw  = slot_ext[IW-1:0];
    assign slot_ok  = (slot_ext < (IW+6)'(SLOTS)) && in_ring(slot_iw, r_head, r_tail);
    assign eidx     = IW'(r_idx - CW'(1));
    assign prev_it  = prev_slot(r_it);
    assign fin_ext  = {6'b0, fin_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it     <= n_it;
        r_op     <= n_op;
        r_key_x  <= n_key_x;
        r_key_y  <= n_key_y;
        r_best   <= n_best;
        r_bidx   <= n_bidx;
        r_bfound <= n_bfound;
        r_status <= n_status;
        r_found  <= n_found;
        r_onode  <= n_onode;
        r_empty  <= n_empty;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_it       = r_it;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_op       = r_op;
        n_key_x    = r_key_x;
        n_key_y    = r_key_y;
        n_best     = r_best;
        n_bidx     = r_bidx;
        n_bfound   = r_bfound;
        n_done     = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        n_onode    = r_onode;
        n_empty    = r_empty;
        we         = 1'b0;
        waddr      = r_it;
        wdata      = rdata;
        raddr      = '0;
        fin        = 1'b0;
        fin_status = STAT_DONE;
        fin_idx    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_key_x = i_pos_x;
                    n_key_y = i_pos_y;
                    n_onode = '0;
                    unique case (t_op'(i_operation))
                        OP_ADD: begin
                            fin = 1'b1;
                            if (next_slot(r_tail) == r_head) begin
                                fin_status = STAT_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = r_tail;
                                wdata   = '{x: i_pos_x, y: i_pos_y, g: i_path_cost,
                                            h: i_estimate_cost};
                                n_tail  = next_slot(r_tail);
                            end
                        end
                        OP_REMOVE: begin
                            if (!slot_ok) begin
                                fin        = 1'b1;
                                fin_status = STAT_MISS;
                            end else begin
                                raddr   = slot_iw;
                                n_it    = slot_iw;
                                n_state = ST_RMV_CAP;
                            end
                        end
                        OP_FIND, OP_BEST: begin
                            n_idx    = '0;
                            n_pend   = 1'b0;
                            n_best   = COST_LIMIT;
                            n_bidx   = '0;
                            n_bfound = 1'b0;
                            n_state  = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_RMV_CAP: begin
                n_onode = rdata;
                if (r_it == r_head) begin
                    n_head  = next_slot(r_head);
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    raddr   = prev_it;
                    n_state = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                we    = 1'b1;
                waddr = r_it;
                wdata = rdata;
                n_it  = prev_it;
                if (prev_it == r_head) begin
                    n_head  = next_slot(r_head);
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    raddr = prev_slot(prev_it);
                end
            end

            ST_SCAN: begin
                if (r_pend && in_ring(eidx, r_head, r_tail)) begin
                    if (r_op == OP_FIND) begin
                        if (ev.match) begin
                            fin     = 1'b1;
                            fin_idx = eidx;
                        end
                    end else if (ev.less) begin
                        n_best   = ev.sum;
                        n_bidx   = eidx;
                        n_bfound = 1'b1;
                    end
                end
                if (!fin) begin
                    if (r_idx == CW'(SLOTS)) begin
                        fin = 1'b1;
                        if (r_op == OP_BEST && n_bfound) begin
                            fin_idx = n_bidx;
                        end else begin
                            fin_status = STAT_MISS;
                        end
                    end else begin
                        raddr  = r_idx[IW-1:0];
                        n_idx  = r_idx + CW'(1);
                        n_pend = 1'b1;
                    end
                end
                if (fin) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            n_done   = 1'b1;
            n_status = fin_status;
            n_found  = fin_ext[5:0];
            n_empty  = (n_head == n_tail);
        end
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_found_index       = r_found;
    assign o_out_pos_x         = r_onode.x;
    assign o_out_pos_y         = r_onode.y;
    assign o_out_path_cost     = r_onode.g;
    assign o_out_estimate_cost = r_onode.h;
    assign o_is_empty          = r_empty;

endmodule

// ===== hdl/sol_ram.sv =====
// ----------------------------------------------------------------------------
// sol_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sol_ram #(
    parameter int unsigned WIDTH = 80,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sol_eval.sv =====
// ----------------------------------------------------------------------------
// sol_eval
// Shared compare unit of the scan: position match against the search key and
// total cost g+h against the best cost so far.
// ----------------------------------------------------------------------------
module sol_eval (
    input  sol_pkg::t_node                  i_node,
    input  logic [sol_pkg::COORD_W-1:0]     i_key_x,
    input  logic [sol_pkg::COORD_W-1:0]     i_key_y,
    input  logic [sol_pkg::SUM_W-1:0]       i_best,
    output sol_pkg::t_eval                  o_res
);

    import sol_pkg::*;

    logic [SUM_W-1:0] sum;

    assign sum = {1'b0, i_node.g} + {1'b0, i_node.h};

    always_comb begin
        o_res.match = (i_node.x == i_key_x) && (i_node.y == i_key_y);
        o_res.less  = (sum < i_best);
        o_res.sum   = sum;
    end

endmodule
